// File: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

   localparam int ACT_W  = 2;
   localparam int CHAR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int WORD_W = 16;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;
   localparam int RESET_LINE         = 15;

   localparam logic [ACT_W-1:0] ACT_PUT_CURSOR = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PUT_AT     = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ       = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] CELL_ATTR    = 8'h02;

   // sweep regions of the cell store
   localparam int REGION_W = 2;
   localparam logic [REGION_W-1:0] REGION_ALL  = 2'd0;
   localparam logic [REGION_W-1:0] REGION_ROW0 = 2'd1;
   localparam logic [REGION_W-1:0] REGION_COPY = 2'd2;
   localparam logic [REGION_W-1:0] REGION_LAST = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
   } req_type;

   typedef struct packed {
      logic              echo_valid;
      logic [CHAR_W-1:0] echo_char;
      logic [WORD_W-1:0] cell_word;
      logic [COL_W-1:0]  cursor_column;
      logic [ROW_W-1:0]  cursor_row;
      logic              position_error;
   } rsp_type;

   typedef struct packed {
      logic                take;
      logic                adv;
      logic                finish;
      logic                fill;
      logic                copy_rd;
      logic                cnt_load;
      logic                cnt_inc;
      logic [REGION_W-1:0] region;
      logic                clear_pending;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic needs_scroll;
      logic advance;
      logic cnt_last;
      logic pending_clear;
      logic slot_free;
   } status_type;

endpackage

`default_nettype wire

// File: design/tcw_datapath.sv
`default_nettype none

module tcw_datapath #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tcw_pkg::req_type    req_data,
   input  wire tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type      status,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output tcw_pkg::rsp_type         rsp_data
);

   localparam int DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int INIT_LINE = (tcw_pkg::RESET_LINE <= SCREEN_ROWS - 2) ?
                              tcw_pkg::RESET_LINE : SCREEN_ROWS - 2;

   localparam logic [AW-1:0] COLS_A      = AW'(SCREEN_COLUMNS);
   localparam logic [AW-1:0] ALL_END     = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROW0_END    = AW'(SCREEN_COLUMNS - 1);
   localparam logic [AW-1:0] COPY_START  = AW'(2 * SCREEN_COLUMNS);
   localparam logic [AW-1:0] LAST_START  = AW'((SCREEN_ROWS - 2) * SCREEN_COLUMNS);
   localparam logic [AW-1:0] REGION_END  = AW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS - 1);

   localparam logic [tcw_pkg::COL_W-1:0] COLS_C  = tcw_pkg::COL_W'(SCREEN_COLUMNS);
   localparam logic [tcw_pkg::ROW_W-1:0] ROWS_R  = tcw_pkg::ROW_W'(SCREEN_ROWS);
   localparam logic [tcw_pkg::ROW_W-1:0] BOT_ROW = tcw_pkg::ROW_W'(SCREEN_ROWS - 2);
   localparam logic [tcw_pkg::ROW_W:0]   SCROLL_AT = (tcw_pkg::ROW_W + 1)'(SCREEN_ROWS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0] INIT_ROW  = tcw_pkg::ROW_W'(INIT_LINE);

   logic [tcw_pkg::CHAR_W-1:0] cell_mem_ff [DEPTH];
   logic [tcw_pkg::CHAR_W-1:0] rdata_ff;

   tcw_pkg::req_type item_ff;
   tcw_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [tcw_pkg::COL_W-1:0] col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0] line_ff, line_in;
   logic pending_ff, pending_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic pend_wr_ff, pend_wr_in;
   logic [AW-1:0] pend_addr_ff;

   logic is_put_cursor, is_nl, wrap, on_screen, printable;
   logic [tcw_pkg::ROW_W:0]   line_plus;
   logic [tcw_pkg::ROW_W-1:0] adv_line, pos_line;
   logic [tcw_pkg::COL_W-1:0] pos_col;
   logic [AW-1:0] cursor_addr, target_addr, cnt_end, start_addr;
   logic we, re;
   logic [AW-1:0] wa, ra;
   logic [tcw_pkg::CHAR_W-1:0] wd;

   assign is_put_cursor = item_ff.action == tcw_pkg::ACT_PUT_CURSOR;
   assign is_nl         = item_ff.char_code == tcw_pkg::NEWLINE_CHAR;
   assign printable     = is_put_cursor && !is_nl;
   assign wrap          = col_ff >= COLS_C;
   assign on_screen     = (item_ff.column < COLS_C) && (item_ff.row < ROWS_R);
   assign line_plus     = {1'b0, line_ff} + 1'b1;
   assign adv_line      = (line_plus >= SCROLL_AT) ? BOT_ROW : line_plus[tcw_pkg::ROW_W-1:0];
   assign pos_line      = cmd.adv ? adv_line : line_ff;
   assign pos_col       = cmd.adv ? '0 : col_ff;
   assign cursor_addr   = AW'(pos_line) * COLS_A + AW'(pos_col);
   assign target_addr   = AW'(item_ff.row) * COLS_A + AW'(item_ff.column);

   always_comb begin
      case (cmd.region)
         tcw_pkg::REGION_ALL:  cnt_end = ALL_END;
         tcw_pkg::REGION_ROW0: cnt_end = ROW0_END;
         default:              cnt_end = REGION_END;
      endcase
      // the row-0 sweep hands its counter over to the copy
      case (cmd.region)
         tcw_pkg::REGION_ROW0: start_addr = COPY_START;
         tcw_pkg::REGION_COPY: start_addr = COPY_START;
         tcw_pkg::REGION_LAST: start_addr = LAST_START;
         default:              start_addr = '0;
      endcase
   end

   assign status.advance       = is_put_cursor && (is_nl || wrap);
   assign status.needs_scroll  = status.advance && (line_plus >= SCROLL_AT);
   assign status.cnt_last      = cnt_ff == cnt_end;
   assign status.pending_clear = pending_ff;
   assign status.slot_free     = !rsp_valid_ff || !rsp_stall;

   // single write port, single registered read port
   always_comb begin
      we = 1'b0;
      wa = cnt_ff;
      wd = tcw_pkg::BLANK_CHAR;
      re = 1'b0;
      ra = cnt_ff;
      if (cmd.fill) begin
         we = 1'b1;
      end else if (pend_wr_ff) begin
         we = 1'b1;
         wa = pend_addr_ff;
         wd = rdata_ff;
      end else if (cmd.finish) begin
         if (printable) begin
            we = 1'b1;
            wa = cursor_addr;
            wd = item_ff.char_code;
         end else if (item_ff.action == tcw_pkg::ACT_PUT_AT && on_screen) begin
            we = 1'b1;
            wa = target_addr;
            wd = item_ff.char_code;
         end
      end
      if (cmd.copy_rd) begin
         re = 1'b1;
      end else if (cmd.finish && item_ff.action == tcw_pkg::ACT_READ && on_screen) begin
         re = 1'b1;
         ra = target_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         cell_mem_ff[wa] <= wd;
      end
      if (re) begin
         rdata_ff <= cell_mem_ff[ra];
      end
   end

   always_comb begin
      col_in     = col_ff;
      line_in    = line_ff;
      pending_in = pending_ff;
      cnt_in     = cnt_ff;
      pend_wr_in = cmd.copy_rd;
      if (cmd.adv) begin
         col_in  = '0;
         line_in = adv_line;
      end
      if (cmd.finish && printable) begin
         col_in = pos_col + 1'b1;
      end
      if (cmd.clear_pending) begin
         pending_in = 1'b0;
      end
      if (cmd.cnt_load) begin
         cnt_in = start_addr;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in.echo_valid     = (item_ff.action == tcw_pkg::ACT_PUT_CURSOR && !is_nl) ||
                              (item_ff.action == tcw_pkg::ACT_PUT_AT && on_screen);
      rsp_in.echo_char      = rsp_in.echo_valid ? item_ff.char_code : '0;
      rsp_in.cell_word      = (item_ff.action == tcw_pkg::ACT_READ && on_screen) ?
                              {tcw_pkg::CELL_ATTR, rdata_ff} : '0;
      rsp_in.cursor_column  = col_ff;
      rsp_in.cursor_row     = line_ff;
      rsp_in.position_error = (item_ff.action == tcw_pkg::ACT_PUT_AT ||
                               item_ff.action == tcw_pkg::ACT_READ) && !on_screen;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= INIT_ROW;
         pending_ff   <= 1'b1;
         cnt_ff       <= '0;
         pend_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         pending_ff   <= pending_in;
         cnt_ff       <= cnt_in;
         pend_wr_ff   <= pend_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_ff <= req_data;
      end
      if (cmd.copy_rd) begin
         pend_addr_ff <= cnt_ff - COLS_A;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: design/tcw_controller.sv
`default_nettype none

module tcw_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire tcw_pkg::status_type status,
   output tcw_pkg::cmd_type         cmd
);

   localparam logic [2:0] S_INIT     = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_EXEC     = 3'd2;
   localparam logic [2:0] S_ROW0     = 3'd3;
   localparam logic [2:0] S_COPY     = 3'd4;
   localparam logic [2:0] S_COPY_END = 3'd5;
   localparam logic [2:0] S_LAST     = 3'd6;
   localparam logic [2:0] S_OUT      = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       post_ff, post_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff;
      post_in  = post_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.region  = tcw_pkg::REGION_ALL;
            cmd.fill    = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (post_ff) begin
               cmd.finish = 1'b1;
               post_in    = 1'b0;
               state_in   = S_OUT;
            end else if (status.needs_scroll) begin
               cmd.adv      = 1'b1;
               cmd.cnt_load = 1'b1;
               post_in      = 1'b1;
               if (status.pending_clear) begin
                  cmd.region = tcw_pkg::REGION_ALL;
                  state_in   = S_ROW0;
               end else begin
                  cmd.region = tcw_pkg::REGION_COPY;
                  state_in   = S_COPY;
               end
            end else begin
               cmd.adv    = status.advance;
               cmd.finish = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_ROW0: begin
            cmd.region = tcw_pkg::REGION_ROW0;
            cmd.fill   = 1'b1;
            if (status.cnt_last) begin
               cmd.cnt_load      = 1'b1;
               cmd.clear_pending = 1'b1;
               state_in          = S_COPY;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_COPY: begin
            cmd.region  = tcw_pkg::REGION_COPY;
            cmd.copy_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) begin
               state_in = S_COPY_END;
            end
         end
         S_COPY_END: begin
            cmd.region   = tcw_pkg::REGION_LAST;
            cmd.cnt_load = 1'b1;
            state_in     = S_LAST;
         end
         S_LAST: begin
            cmd.region  = tcw_pkg::REGION_LAST;
            cmd.fill    = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.cnt_last) begin
               state_in = S_EXEC;
            end
         end
         S_OUT: begin
            if (status.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         post_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
      end
   end

endmodule

`default_nettype wire

// File: design/text_console_writer.sv
// An accepted transaction passes the controller's accept, execute and result states in turn.
// A new transaction is accepted only in the idle state, after the last result is registered.
// A scroll adds copy and clear sweeps on the single-port cell store before the write, and
// the first scroll also sweeps row 0 to blank it.
// Reset: synchronous; afterwards a clearing pass writes spaces to all COLUMNS*ROWS cells
// with req_stall high; cursor starts at column 0, row min(15, ROWS-2).
`default_nettype none

module text_console_writer #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tcw_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tcw_pkg::rsp_type      rsp_data
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: design/tcw_checker.sv
`default_nettype none

module tcw_checker #(
   parameter int SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire tcw_pkg::rsp_type rsp_data
);

   localparam logic [tcw_pkg::ROW_W-1:0] MAX_ROW = tcw_pkg::ROW_W'(SCREEN_ROWS - 2);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cursor_row <= MAX_ROW)
      else $error("cursor row past the scroll row");

   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.echo_valid |-> rsp_data.echo_char == '0)
      else $error("echo char without echo");

   a_pos_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.position_error |->
         !rsp_data.echo_valid && rsp_data.cell_word == '0)
      else $error("off-screen position produced data");

   a_attr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cell_word != '0 |->
         rsp_data.cell_word[15:8] == tcw_pkg::CELL_ATTR && !rsp_data.echo_valid)
      else $error("bad cell attribute");

endmodule

bind text_console_writer tcw_checker #(.SCREEN_ROWS(SCREEN_ROWS)) u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: bench/tb_text_console_writer.sv
`timescale 1ns / 100ps

module tb_text_console_writer;

   localparam int COLS            = tcw_pkg::DEF_SCREEN_COLUMNS;
   localparam int ROWS            = tcw_pkg::DEF_SCREEN_ROWS;
   localparam int COL_MAX         = 2**tcw_pkg::COL_W - 1;
   localparam int ROW_MAX         = 2**tcw_pkg::ROW_W - 1;
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 20;

   localparam logic [tcw_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   tcw_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   tcw_pkg::rsp_type rsp_data;

   // predicted console state
   logic [tcw_pkg::CHAR_W-1:0] screen_img [COLS*ROWS];
   int unsigned                cursor_x;
   int unsigned                cursor_y;
   bit                         row0_clear_pending;
   tcw_pkg::rsp_type           console_rsp_q [$];

   logic [tcw_pkg::COL_W-1:0] last_put_col = '0;
   logic [tcw_pkg::ROW_W-1:0] last_put_row = '0;
   bit          steady_mode  = 1'b0;
   bit          hold_off_req = 1'b0;
   int unsigned n_sent    = 0;
   int unsigned n_checked = 0;
   int unsigned n_scrolls = 0;
   int unsigned n_wraps   = 0;
   int unsigned n_perr    = 0;
   int unsigned n_fail    = 0;

   text_console_writer #(
      .SCREEN_COLUMNS(COLS),
      .SCREEN_ROWS   (ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_screen_row(int unsigned r);
      for (int c = 0; c < COLS; c++)
         screen_img[r*COLS + c] = tcw_pkg::BLANK_CHAR;
   endfunction

   function automatic void advance_line();
      cursor_x = 0;
      cursor_y++;
      if (cursor_y >= ROWS - 1) begin
         if (row0_clear_pending) begin
            clear_screen_row(0);
            row0_clear_pending = 1'b0;
         end
         for (int i = COLS; i < (ROWS - 2)*COLS; i++)
            screen_img[i] = screen_img[i + COLS];
         clear_screen_row(ROWS - 2);
         cursor_y = ROWS - 2;
         n_scrolls++;
      end
   endfunction

   function automatic tcw_pkg::rsp_type apply_command(tcw_pkg::req_type cmd);
      tcw_pkg::rsp_type r;
      bit               on_screen;
      r = '0;
      on_screen = (cmd.column < COLS) && (cmd.row < ROWS);
      case (cmd.action)
         tcw_pkg::ACT_PUT_CURSOR: begin
            if (cmd.char_code == tcw_pkg::NEWLINE_CHAR) begin
               advance_line();
            end else begin
               if (cursor_x >= COLS) begin
                  n_wraps++;
                  advance_line();
               end
               if (cursor_y < ROWS && cursor_x < COLS)
                  screen_img[cursor_y*COLS + cursor_x] = cmd.char_code;
               cursor_x++;
               r.echo_valid = 1'b1;
               r.echo_char  = cmd.char_code;
            end
         end
         tcw_pkg::ACT_PUT_AT: begin
            if (on_screen) begin
               screen_img[cmd.row*COLS + cmd.column] = cmd.char_code;
               r.echo_valid = 1'b1;
               r.echo_char  = cmd.char_code;
            end else begin
               r.position_error = 1'b1;
            end
         end
         tcw_pkg::ACT_READ: begin
            if (on_screen)
               r.cell_word = {tcw_pkg::CELL_ATTR, screen_img[cmd.row*COLS + cmd.column]};
            else
               r.position_error = 1'b1;
         end
         default: ;
      endcase
      r.cursor_column = cursor_x[tcw_pkg::COL_W-1:0];
      r.cursor_row    = cursor_y[tcw_pkg::ROW_W-1:0];
      if (r.position_error)
         n_perr++;
      return r;
   endfunction

   function automatic tcw_pkg::req_type make_cmd(input logic [tcw_pkg::ACT_W-1:0] act,
                                                 input logic [tcw_pkg::CHAR_W-1:0] ch,
                                                 input int unsigned c,
                                                 input int unsigned r);
      tcw_pkg::req_type cmd;
      cmd.action    = act;
      cmd.char_code = ch;
      cmd.column    = c[tcw_pkg::COL_W-1:0];
      cmd.row       = r[tcw_pkg::ROW_W-1:0];
      return cmd;
   endfunction

   function automatic logic [tcw_pkg::CHAR_W-1:0] non_newline_byte();
      logic [tcw_pkg::CHAR_W-1:0] b;
      do b = tcw_pkg::CHAR_W'($urandom_range(0, 255)); while (b == tcw_pkg::NEWLINE_CHAR);
      return b;
   endfunction

   function automatic int unsigned idle_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic tcw_pkg::req_type random_cmd();
      tcw_pkg::req_type cmd;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      cmd.char_code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
      if ($urandom_range(0, 6) == 0) begin
         cmd.column = tcw_pkg::COL_W'($urandom_range(0, COL_MAX));
         cmd.row    = tcw_pkg::ROW_W'($urandom_range(0, ROW_MAX));
      end else begin
         cmd.column = tcw_pkg::COL_W'($urandom_range(0, COLS - 1));
         cmd.row    = tcw_pkg::ROW_W'($urandom_range(0, ROWS - 1));
      end
      if (pick < 40) begin
         cmd.action = tcw_pkg::ACT_PUT_CURSOR;
         if ($urandom_range(0, 9) == 0)
            cmd.char_code = tcw_pkg::NEWLINE_CHAR;
      end else if (pick < 65) begin
         cmd.action   = tcw_pkg::ACT_PUT_AT;
         last_put_col = cmd.column;
         last_put_row = cmd.row;
      end else if (pick < 95) begin
         cmd.action = tcw_pkg::ACT_READ;
         // bias reads toward cells that were just written
         if ($urandom_range(0, 2) == 0) begin
            cmd.column = last_put_col;
            cmd.row    = last_put_row;
         end else if ($urandom_range(0, 1) == 0) begin
            cmd.column = tcw_pkg::COL_W'($urandom_range(0, COLS - 1));
            cmd.row    = cursor_y[tcw_pkg::ROW_W-1:0];
         end
      end else begin
         cmd.action = ACT_UNUSED;
      end
      return cmd;
   endfunction

   task automatic send_cmd(input tcw_pkg::req_type cmd);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (req_stall !== 1'b0);
      console_rsp_q.push_back(apply_command(cmd));
      n_sent++;
      if (!steady_mode && $urandom_range(0, 99) >= 55) begin
         gap = idle_len();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic test_directed();
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, COLS, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, ROWS));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'hFF, COL_MAX, ROW_MAX));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_AT, 8'hFF, 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_AT, 8'h00, COLS - 1, ROWS - 1));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_AT, 8'h55, COLS, ROWS - 1));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_AT, 8'hAA, 5, ROW_MAX));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, 0));
      send_cmd(make_cmd(ACT_UNUSED, 8'hFF, COL_MAX, ROW_MAX));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, 8'h41, 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, 8'h00, COL_MAX, ROW_MAX));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, 8'hFF, 0, 0));
      // walk down to the bottom and through the first scroll
      repeat (ROWS - 1 - cursor_y)
         send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, tcw_pkg::NEWLINE_CHAR, 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, COLS - 1, ROWS - 1));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, 14));
   endtask

   task automatic test_line_wrap();
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, tcw_pkg::NEWLINE_CHAR, 0, 0));
      repeat (2) begin
         for (int i = 0; i < COLS; i++)
            send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, non_newline_byte(), 0, 0));
         send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, COLS - 1, cursor_y));
      end
      // newline while a wrap is pending advances only once
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, tcw_pkg::NEWLINE_CHAR, 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_PUT_CURSOR, non_newline_byte(), 0, 0));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, cursor_y));
      send_cmd(make_cmd(tcw_pkg::ACT_READ, 8'h00, 0, cursor_y - 1));
   endtask

   task automatic test_back_to_back();
      steady_mode = 1'b1;
      repeat (40) send_cmd(random_cmd());
      steady_mode = 1'b0;
   endtask

   task automatic test_backpressure();
      steady_mode  = 1'b1;
      hold_off_req = 1'b1;
      repeat (30) send_cmd(random_cmd());
      steady_mode = 1'b0;
   endtask

   task automatic test_random_mix(int unsigned count);
      repeat (count) send_cmd(random_cmd());
   endtask

   initial begin : rsp_side
      int unsigned n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!steady_mode && $urandom_range(0, 3) == 0) begin
            n = idle_len();
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      tcw_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         n_checked++;
         if (console_rsp_q.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual %p", $time, rsp_data);
            n_fail++;
         end else begin
            want = console_rsp_q.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: result mismatch: expected %p, actual %p", $time, want,
                        rsp_data);
               n_fail++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      foreach (screen_img[i])
         screen_img[i] = tcw_pkg::BLANK_CHAR;
      cursor_x           = 0;
      cursor_y           = (tcw_pkg::RESET_LINE <= ROWS - 2) ? tcw_pkg::RESET_LINE : ROWS - 2;
      row0_clear_pending = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_line_wrap();
      test_back_to_back();
      test_backpressure();
      test_random_mix(380);
      req_valid <= 1'b0;

      while (console_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands, %0d results checked, %0d mismatches.", n_sent, n_checked,
               n_fail);
      $display("Covered %0d scrolls, %0d lazy wraps, %0d off-screen positions.", n_scrolls,
               n_wraps, n_perr);
      if (n_fail == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
